// ===== rtl/core/grns_pkg.sv =====
// shared types, codes and constants for the grid radius neighbour search unit
package grns_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 24;
	localparam int CELL_W         = 25;
	localparam int SIZE_W         = 23;
	localparam int INDEX_W        = 6;
	localparam int NUM_CELLS      = 9;
	localparam int CELL_SEL_W     = 4;
	localparam int DIST_W         = 50;
	localparam int R2_W           = 46;
	localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 23'd256;

	typedef enum logic [1:0] {
		REQ_BUILD = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_RADIUS = 2'd2,
		REQ_NEIGH = 2'd3
	} req_code_t;

	typedef struct packed {
		logic [1:0]                req_type;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [SIZE_W-1:0]         radius;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] point_index;
		logic               last;
	} res_t;

	// x offset of cell k in the 3x3 walk, x outer
	function automatic logic signed [1:0] off_x(input logic [CELL_SEL_W-1:0] k);
		logic signed [1:0] o;
		if (k < 4'd3)
			o = -2'sd1;
		else if (k < 4'd6)
			o = 2'sd0;
		else
			o = 2'sd1;
		return o;
	endfunction

	// y offset of cell k, y inner
	function automatic logic signed [1:0] off_y(input logic [CELL_SEL_W-1:0] k);
		logic signed [1:0] o;
		case (k)
			4'd0, 4'd3, 4'd6: o = -2'sd1;
			4'd1, 4'd4, 4'd7: o = 2'sd0;
			default:          o = 2'sd1;
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/core/grid_radius_neighbour_search_unit.sv =====
// top level of the grid radius neighbour search unit
// Usage: a request is taken at a clock edge with start high and busy low. req_type
// build empties the point store by resetting the point count (no result); load
// stores a point and its grid cell; radius and neighbour queries return matching
// load indices. Load runs two serial 24-bit floor divisions (x then y).
// Query: after the divisions the store is read once per cycle for each of the
// nine cells, candidates pass a three-stage compare pipeline, and the results
// follow at most one per cycle.
// Results appear on res with res_valid high for exactly one cycle each; the
// receiver cannot stall them. The final result of a query carries last; an empty
// answer is one result with found clear. The last result of a query is shown in the
// cycle after busy falls.
// cell_size is written over the cfg channel (cfg_valid/cfg_ready) while idle; each
// point keeps the cell it got at load time.
// Reset clears the point count and the built flag and sets cell_size to 256.
module grid_radius_neighbour_search_unit #(
	parameter int MAX_POINTS = grns_pkg::MAX_POINTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  grns_pkg::req_t              req,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [grns_pkg::SIZE_W-1:0] cfg_data,
	output logic                        res_valid,
	output grns_pkg::res_t              res
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic                        cmd_latch, cmd_div_go, cmd_div_sel, cmd_wr, cmd_rd, cmd_fin;
	logic [AW-1:0]               cmd_wr_addr, cmd_rd_addr;
	logic [grns_pkg::CELL_SEL_W-1:0] cmd_cell;
	logic                        div_done;

	assign cfg_ready = !busy;

	grns_ctrl #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req.req_type),
		.div_done    (div_done),
		.busy        (busy),
		.cmd_latch   (cmd_latch),
		.cmd_div_go  (cmd_div_go),
		.cmd_div_sel (cmd_div_sel),
		.cmd_wr      (cmd_wr),
		.cmd_wr_addr (cmd_wr_addr),
		.cmd_rd      (cmd_rd),
		.cmd_rd_addr (cmd_rd_addr),
		.cmd_cell    (cmd_cell),
		.cmd_fin     (cmd_fin)
	);

	grns_dp #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cmd_latch   (cmd_latch),
		.cmd_div_go  (cmd_div_go),
		.cmd_div_sel (cmd_div_sel),
		.cmd_wr      (cmd_wr),
		.cmd_wr_addr (cmd_wr_addr),
		.cmd_rd      (cmd_rd),
		.cmd_rd_addr (cmd_rd_addr),
		.cmd_cell    (cmd_cell),
		.cmd_fin     (cmd_fin),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.div_done    (div_done),
		.res_valid   (res_valid),
		.res         (res)
	);

	// an empty answer always closes its query
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> res.last)
		else $error("empty result without last");

	// a build request never makes the block busy
	a_build_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == grns_pkg::REQ_BUILD) |=> !busy)
		else $error("build left the block busy");

	// the final transaction of a query follows the fall of busy
	a_last_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |-> !$past(busy))
		else $error("last result while busy");

endmodule

// ===== rtl/core/grns_div.sv =====
// serial floor divider: signed coordinate by unsigned cell size, one bit per cycle
module grns_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 go,
	input  logic signed [grns_pkg::COORD_W-1:0]  num,
	input  logic [grns_pkg::SIZE_W-1:0]          den,
	output logic                                 done,
	output logic signed [grns_pkg::CELL_W-1:0]   quot
);
	localparam int W = grns_pkg::COORD_W;

	logic [W-1:0]   mag_q;
	logic [W-1:0]   rem_q;
	logic           neg_q;
	logic [4:0]     cnt_q;
	logic           run_q;
	logic           done_q;
	logic [W:0]     rem_sh;
	logic           fits;
	logic [W-1:0]   abs_num;

	assign abs_num = num[W-1] ? W'(-num) : W'(num);
	assign rem_sh  = {rem_q, mag_q[W-1]};
	assign fits    = rem_sh >= (W+1)'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into mag_q as the dividend bits shift out
	always_ff @(posedge clk) begin
		if (go) begin
			mag_q <= abs_num;
			rem_q <= '0;
			neg_q <= num[W-1];
		end else if (run_q) begin
			rem_q <= fits ? W'(rem_sh - (W+1)'(den)) : rem_sh[W-1:0];
			mag_q <= {mag_q[W-2:0], fits};
		end
	end

	always_comb begin
		if (!neg_q)
			quot = $signed({1'b0, mag_q});
		else if (rem_q != '0)
			quot = -$signed({1'b0, mag_q}) - 25'sd1;
		else
			quot = -$signed({1'b0, mag_q});
	end

	assign done = done_q;

endmodule

// ===== rtl/core/grns_dp.sv =====
// datapath: point store, divider, candidate pipeline and result register
module grns_dp #(
	parameter int MAX_POINTS = grns_pkg::MAX_POINTS_DEF,
	parameter int AW = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  grns_pkg::req_t             req,
	input  logic                       cmd_latch,
	input  logic                       cmd_div_go,
	input  logic                       cmd_div_sel,
	input  logic                       cmd_wr,
	input  logic [AW-1:0]              cmd_wr_addr,
	input  logic                       cmd_rd,
	input  logic [AW-1:0]              cmd_rd_addr,
	input  logic [grns_pkg::CELL_SEL_W-1:0] cmd_cell,
	input  logic                       cmd_fin,
	input  logic                       cfg_we,
	input  logic [grns_pkg::SIZE_W-1:0] cfg_data,
	output logic                       div_done,
	output logic                       res_valid,
	output grns_pkg::res_t             res
);
	localparam int CW = grns_pkg::COORD_W;
	localparam int LW = grns_pkg::CELL_W;

	logic signed [CW-1:0] px_mem [MAX_POINTS];
	logic signed [CW-1:0] py_mem [MAX_POINTS];
	logic signed [LW-1:0] cx_mem [MAX_POINTS];
	logic signed [LW-1:0] cy_mem [MAX_POINTS];

	logic [grns_pkg::SIZE_W-1:0] cs_q;
	grns_pkg::req_t              req_q;
	logic [grns_pkg::R2_W-1:0]   r2_q;
	logic signed [LW-1:0]        cx_q, cy_q;

	logic [grns_pkg::SIZE_W-1:0] den;
	logic signed [LW-1:0]        quot;

	logic                        v_s1, v_s2, v_s3;
	logic [AW-1:0]               idx_s1, idx_s2, idx_s3;
	logic [grns_pkg::CELL_SEL_W-1:0] k_s1;
	logic signed [CW-1:0]        px_s1, py_s1;
	logic signed [LW-1:0]        cx_s1, cy_s1;
	logic                        m_s2, m_s3;
	logic [LW-1:0]               ax_s2, ay_s2;
	logic [grns_pkg::DIST_W-1:0] sqx_s3, sqy_s3;

	logic signed [LW:0]          tx, ty;
	logic                        cell_hit;
	logic signed [LW-1:0]        ddx, ddy;
	logic [grns_pkg::DIST_W-1:0] d2;
	logic                        hit;

	logic                        pend_v_q;
	logic [AW-1:0]               pend_q;
	logic                        res_valid_q;
	grns_pkg::res_t              res_q;

	assign den = (cs_q == '0) ? grns_pkg::SIZE_W'(1) : cs_q;

	grns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd_div_go),
		.num    (cmd_div_sel ? req_q.pos_y : req_q.pos_x),
		.den    (den),
		.done   (div_done),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cs_q <= grns_pkg::CELL_SIZE_RESET;
		else if (cfg_we)
			cs_q <= cfg_data;
	end

	always_ff @(posedge clk) begin
		if (cmd_latch) begin
			req_q <= req;
			r2_q  <= grns_pkg::R2_W'(req.radius) * grns_pkg::R2_W'(req.radius);
		end
		if (div_done) begin
			if (cmd_div_sel)
				cy_q <= quot;
			else
				cx_q <= quot;
		end
		if (cmd_wr) begin
			px_mem[cmd_wr_addr] <= req_q.pos_x;
			py_mem[cmd_wr_addr] <= req_q.pos_y;
			cx_mem[cmd_wr_addr] <= cx_q;
			cy_mem[cmd_wr_addr] <= cy_q;
		end
		if (cmd_rd) begin
			px_s1 <= px_mem[cmd_rd_addr];
			py_s1 <= py_mem[cmd_rd_addr];
			cx_s1 <= cx_mem[cmd_rd_addr];
			cy_s1 <= cy_mem[cmd_rd_addr];
		end
		idx_s1 <= cmd_rd_addr;
		k_s1   <= cmd_cell;
		idx_s2 <= idx_s1;
		m_s2   <= cell_hit;
		ax_s2  <= ddx[LW-1] ? LW'(-ddx) : LW'(ddx);
		ay_s2  <= ddy[LW-1] ? LW'(-ddy) : LW'(ddy);
		idx_s3 <= idx_s2;
		m_s3   <= m_s2;
		sqx_s3 <= grns_pkg::DIST_W'(ax_s2 * ax_s2);
		sqy_s3 <= grns_pkg::DIST_W'(ay_s2 * ay_s2);
	end

	// candidate checks on the registered store read
	always_comb begin
		tx       = (LW+1)'(cx_q) + (LW+1)'(grns_pkg::off_x(k_s1));
		ty       = (LW+1)'(cy_q) + (LW+1)'(grns_pkg::off_y(k_s1));
		cell_hit = ((LW+1)'(cx_s1) == tx) && ((LW+1)'(cy_s1) == ty);
		ddx      = LW'(px_s1) - LW'(req_q.pos_x);
		ddy      = LW'(py_s1) - LW'(req_q.pos_y);
		d2       = sqx_s3 + sqy_s3;
		hit      = v_s3 && m_s3 &&
		           (req_q.req_type == grns_pkg::REQ_NEIGH ||
		            d2 <= grns_pkg::DIST_W'(r2_q));
	end

	// one match is held back so that the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= cmd_rd;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			res_valid_q <= 1'b0;
			if (hit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q)
					res_valid_q <= 1'b1;
			end
			if (cmd_fin) begin
				res_valid_q <= 1'b1;
				pend_v_q    <= 1'b0;
			end
			if (cmd_latch)
				pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			pend_q <= idx_s3;
			res_q  <= '{found: 1'b1,
			           point_index: grns_pkg::INDEX_W'(pend_q), last: 1'b0};
		end
		if (cmd_fin)
			res_q <= '{found: pend_v_q,
			           point_index: pend_v_q ? grns_pkg::INDEX_W'(pend_q) : '0,
			           last: 1'b1};
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/grns_ctrl.sv =====
// controller: request decode, point count and the 3x3 cell by point scan
module grns_ctrl #(
	parameter int MAX_POINTS = grns_pkg::MAX_POINTS_DEF,
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [1:0]                 req_type,
	input  logic                       div_done,
	output logic                       busy,
	output logic                       cmd_latch,
	output logic                       cmd_div_go,
	output logic                       cmd_div_sel,
	output logic                       cmd_wr,
	output logic [AW-1:0]              cmd_wr_addr,
	output logic                       cmd_rd,
	output logic [AW-1:0]              cmd_rd_addr,
	output logic [grns_pkg::CELL_SEL_W-1:0] cmd_cell,
	output logic                       cmd_fin
);
	typedef enum logic [2:0] {ST_IDLE, ST_DIVX, ST_DIVY, ST_SCAN, ST_DRAIN} state_t;

	localparam logic [2:0] DRAIN_LAST = 3'd3;

	state_t                       state_q;
	logic [CW-1:0]                count_q;
	logic                         built_q;
	logic                         query_q;
	logic                         div_go_q, div_sel_q, wr_q, rd_q, fin_q;
	logic [AW-1:0]                wr_addr_q, rd_addr_q;
	logic [grns_pkg::CELL_SEL_W-1:0] cell_q;
	logic [2:0]                   drain_q;

	assign busy      = (state_q != ST_IDLE);
	assign cmd_latch = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			built_q   <= 1'b0;
			query_q   <= 1'b0;
			div_go_q  <= 1'b0;
			div_sel_q <= 1'b0;
			wr_q      <= 1'b0;
			rd_q      <= 1'b0;
			fin_q     <= 1'b0;
			wr_addr_q <= '0;
			rd_addr_q <= '0;
			cell_q    <= '0;
			drain_q   <= '0;
		end else begin
			div_go_q <= 1'b0;
			wr_q     <= 1'b0;
			fin_q    <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (req_type)
							grns_pkg::REQ_BUILD: begin
								count_q <= '0;
								built_q <= 1'b1;
							end
							grns_pkg::REQ_LOAD: begin
								if (built_q && count_q < CW'(MAX_POINTS)) begin
									div_go_q  <= 1'b1;
									div_sel_q <= 1'b0;
									query_q   <= 1'b0;
									state_q   <= ST_DIVX;
								end
							end
							default: begin
								if (built_q) begin
									div_go_q  <= 1'b1;
									div_sel_q <= 1'b0;
									query_q   <= 1'b1;
									state_q   <= ST_DIVX;
								end else begin
									fin_q <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						div_go_q  <= 1'b1;
						div_sel_q <= 1'b1;
						state_q   <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						if (!query_q) begin
							wr_q      <= 1'b1;
							wr_addr_q <= AW'(count_q);
							count_q   <= count_q + CW'(1);
							state_q   <= ST_IDLE;
						end else if (count_q == '0) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							rd_q      <= 1'b1;
							rd_addr_q <= '0;
							cell_q    <= '0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (CW'(rd_addr_q) == count_q - CW'(1)) begin
						rd_addr_q <= '0;
						if (cell_q == grns_pkg::CELL_SEL_W'(grns_pkg::NUM_CELLS - 1)) begin
							rd_q    <= 1'b0;
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							cell_q <= cell_q + grns_pkg::CELL_SEL_W'(1);
						end
					end else begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					// let the last candidates leave the pipeline
					drain_q <= drain_q + 3'd1;
					if (drain_q == DRAIN_LAST) begin
						fin_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd_div_go  = div_go_q;
	assign cmd_div_sel = div_sel_q;
	assign cmd_wr      = wr_q;
	assign cmd_wr_addr = wr_addr_q;
	assign cmd_rd      = rd_q;
	assign cmd_rd_addr = rd_addr_q;
	assign cmd_cell    = cell_q;
	assign cmd_fin     = fin_q;

endmodule
